[rtl/insdec_pkg.sv]
// shared types and constants of the instruction decoder
package insdec_pkg;

    // instruction word width and mnemonic code width
    localparam int unsigned WORD_W = 14;
    localparam int unsigned MNEM_W = 6;

    // format selection after reset: 1 = 14-bit mid-range
    localparam logic ISA_MODE_RESET = 1'b1;
    localparam logic ISA_BASELINE   = 1'b0;

    // dense mnemonic codes
    typedef enum logic [MNEM_W-1:0] {
        MN_NOP    = 6'd0,
        MN_OPTION = 6'd1,
        MN_SLEEP  = 6'd2,
        MN_CLRWDT = 6'd3,
        MN_TRIS   = 6'd4,
        MN_MOVWF  = 6'd5,
        MN_CLRW   = 6'd6,
        MN_CLRF   = 6'd7,
        MN_SUBWF  = 6'd8,
        MN_DECF   = 6'd9,
        MN_IORWF  = 6'd10,
        MN_ANDWF  = 6'd11,
        MN_XORWF  = 6'd12,
        MN_ADDWF  = 6'd13,
        MN_MOVF   = 6'd14,
        MN_COMF   = 6'd15,
        MN_INCF   = 6'd16,
        MN_DECFSZ = 6'd17,
        MN_RRF    = 6'd18,
        MN_RLF    = 6'd19,
        MN_SWAPF  = 6'd20,
        MN_INCFSZ = 6'd21,
        MN_BCF    = 6'd22,
        MN_BSF    = 6'd23,
        MN_BTFSC  = 6'd24,
        MN_BTFSS  = 6'd25,
        MN_GOTO   = 6'd26,
        MN_CALL   = 6'd27,
        MN_RETLW  = 6'd28,
        MN_MOVLW  = 6'd29,
        MN_IORLW  = 6'd30,
        MN_ANDLW  = 6'd31,
        MN_XORLW  = 6'd32,
        MN_RETURN = 6'd33,
        MN_RETFIE = 6'd34,
        MN_SUBLW  = 6'd35,
        MN_ADDLW  = 6'd36,
        MN_DATA   = 6'd37
    } mnemonic_t;

    // one decoded instruction
    typedef struct packed {
        mnemonic_t         mnemonic;
        logic [6:0]        file_addr;
        logic              dest_is_file;
        logic [2:0]        bit_index;
        logic [7:0]        literal;
        logic [10:0]       target;
        logic [2:0]        tris_port;
        logic [WORD_W-1:0] raw_word;
    } decode_result_t;

endpackage

[rtl/insdec_decode.sv]
// combinational decode of one baseline or mid-range program word
module insdec_decode (
    input  logic                           isa_mode,
    input  logic [insdec_pkg::WORD_W-1:0]  instr_word,
    output insdec_pkg::decode_result_t     result
);
    import insdec_pkg::*;

    logic [11:0] w12;
    logic [13:0] w14;

    assign w12 = instr_word[11:0];
    assign w14 = instr_word[13:0];

    always_comb begin
        result          = '0;
        result.mnemonic = MN_DATA;
        if (isa_mode == ISA_BASELINE) begin
            // 12-bit baseline format
            result.raw_word = {2'b00, w12};
            unique case (w12[11:10])
                2'b00: begin
                    if (w12[9:6] == 4'd0) begin
                        // control words and movwf
                        if (w12[5]) begin
                            result.mnemonic  = MN_MOVWF;
                            result.file_addr = {2'b00, w12[4:0]};
                        end else begin
                            unique case (w12[7:0]) inside
                                8'h00: result.mnemonic = MN_NOP;
                                8'h02: result.mnemonic = MN_OPTION;
                                8'h03: result.mnemonic = MN_SLEEP;
                                8'h04: result.mnemonic = MN_CLRWDT;
                                8'h05, 8'h06, 8'h07: begin
                                    result.mnemonic  = MN_TRIS;
                                    result.tris_port = w12[2:0];
                                end
                                default: result.mnemonic = MN_DATA;
                            endcase
                        end
                    end else if (w12[9:6] == 4'd1) begin
                        // clear group
                        if (w12[7:0] == 8'h40) begin
                            result.mnemonic = MN_CLRW;
                        end else if (w12[5]) begin
                            result.mnemonic  = MN_CLRF;
                            result.file_addr = {2'b00, w12[4:0]};
                        end
                    end else begin
                        // byte operations
                        result.mnemonic     = mnemonic_t'(6'(MN_CLRW) + {2'b00, w12[9:6]});
                        result.file_addr    = {2'b00, w12[4:0]};
                        result.dest_is_file = w12[5];
                    end
                end
                2'b01: begin
                    // bit operations
                    result.mnemonic  = mnemonic_t'(6'(MN_BCF) + {4'b0000, w12[9:8]});
                    result.file_addr = {2'b00, w12[4:0]};
                    result.bit_index = w12[7:5];
                end
                2'b10: begin
                    // goto, call, retlw
                    if (w12[9]) begin
                        result.mnemonic = MN_GOTO;
                        result.target   = {2'b00, w12[8:0]};
                    end else if (w12[8]) begin
                        result.mnemonic = MN_CALL;
                        result.literal  = w12[7:0];
                        result.target   = {3'b000, w12[7:0]};
                    end else begin
                        result.mnemonic = MN_RETLW;
                        result.literal  = w12[7:0];
                    end
                end
                default: begin
                    // literal operations
                    result.mnemonic = mnemonic_t'(6'(MN_MOVLW) + {4'b0000, w12[9:8]});
                    result.literal  = w12[7:0];
                end
            endcase
        end else begin
            // 14-bit mid-range format
            result.raw_word = w14;
            unique case (w14[13:12])
                2'b00: begin
                    if (w14[11:8] == 4'd0) begin
                        // control words and movwf
                        if (w14[7]) begin
                            result.mnemonic  = MN_MOVWF;
                            result.file_addr = w14[6:0];
                        end else begin
                            unique case (w14[7:0]) inside
                                8'h08: result.mnemonic = MN_RETURN;
                                8'h09: result.mnemonic = MN_RETFIE;
                                8'h62: result.mnemonic = MN_OPTION;
                                8'h63: result.mnemonic = MN_SLEEP;
                                8'h64: result.mnemonic = MN_CLRWDT;
                                8'h65, 8'h66, 8'h67: begin
                                    result.mnemonic  = MN_TRIS;
                                    result.tris_port = w14[2:0];
                                end
                                8'h00, 8'h20, 8'h40, 8'h60: result.mnemonic = MN_NOP;
                                default: result.mnemonic = MN_DATA;
                            endcase
                        end
                    end else if (w14[11:8] == 4'd1) begin
                        // clear group
                        if (w14[7:0] == 8'h03) begin
                            result.mnemonic = MN_CLRW;
                        end else if (w14[7]) begin
                            result.mnemonic  = MN_CLRF;
                            result.file_addr = w14[6:0];
                        end
                    end else begin
                        // byte operations
                        result.mnemonic     = mnemonic_t'(6'(MN_CLRW) + {2'b00, w14[11:8]});
                        result.file_addr    = w14[6:0];
                        result.dest_is_file = w14[7];
                    end
                end
                2'b01: begin
                    // bit operations
                    result.mnemonic  = mnemonic_t'(6'(MN_BCF) + {4'b0000, w14[11:10]});
                    result.file_addr = w14[6:0];
                    result.bit_index = w14[9:7];
                end
                2'b10: begin
                    // goto and call
                    result.mnemonic = w14[11] ? MN_GOTO : MN_CALL;
                    result.target   = w14[10:0];
                end
                default: begin
                    // literal operations, opcode 1011 has no encoding
                    result.literal = w14[7:0];
                    unique case (w14[11:8]) inside
                        [4'd0:4'd3]:   result.mnemonic = MN_MOVLW;
                        [4'd4:4'd7]:   result.mnemonic = MN_RETLW;
                        4'd8:          result.mnemonic = MN_IORLW;
                        4'd9:          result.mnemonic = MN_ANDLW;
                        4'd10:         result.mnemonic = MN_XORLW;
                        4'd11: begin
                            result.mnemonic = MN_DATA;
                            result.literal  = '0;
                        end
                        4'd12, 4'd13:  result.mnemonic = MN_SUBLW;
                        default:       result.mnemonic = MN_ADDLW;
                    endcase
                end
            endcase
        end
    end

endmodule

[rtl/pic_instruction_decoder_top.sv]
// Instruction decoder top level: input register, decode logic, result register.
// A request accepted into the input register reaches m_valid through the result register.
// Throughput: one request per cycle; the input register and the result register
// form a two-entry pipeline with per-stage backpressure.
// Reset: aresetn (synchronous, active low) empties both stages and sets isa_mode to
// 14-bit mid-range.
module pic_instruction_decoder_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration
    input  logic                           cfg_we,
    input  logic                           cfg_wdata,
    // request channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [insdec_pkg::WORD_W-1:0]  s_instr_word,
    // result channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [insdec_pkg::MNEM_W-1:0]  m_mnemonic,
    output logic [6:0]                     m_file_addr,
    output logic                           m_dest_is_file,
    output logic [2:0]                     m_bit_index,
    output logic [7:0]                     m_literal,
    output logic [10:0]                    m_target,
    output logic [2:0]                     m_tris_port,
    output logic [insdec_pkg::WORD_W-1:0]  m_raw_word
);
    import insdec_pkg::*;

    logic                 isa_mode_reg;
    logic                 in_valid_reg;
    logic [WORD_W-1:0]    word_reg;
    logic                 out_valid_reg;
    decode_result_t       result_reg;
    decode_result_t       result_next;
    logic                 out_ready;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            isa_mode_reg <= ISA_MODE_RESET;
        end else if (cfg_we) begin
            isa_mode_reg <= cfg_wdata;
        end
    end

    // stage handshakes
    assign out_ready = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || out_ready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg <= s_instr_word;
        end
    end

    // decode logic
    insdec_decode u_decode (
        .isa_mode   (isa_mode_reg),
        .instr_word (word_reg),
        .result     (result_next)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid_reg && out_ready) begin
            result_reg <= result_next;
        end
    end

    // result outputs
    assign m_valid        = out_valid_reg;
    assign m_mnemonic     = result_reg.mnemonic;
    assign m_file_addr    = result_reg.file_addr;
    assign m_dest_is_file = result_reg.dest_is_file;
    assign m_bit_index    = result_reg.bit_index;
    assign m_literal      = result_reg.literal;
    assign m_target       = result_reg.target;
    assign m_tris_port    = result_reg.tris_port;
    assign m_raw_word     = result_reg.raw_word;

endmodule
